@@ design/stbl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbl_pkg
// Shared types and constants for the sprite tile row blitter.
// ----------------------------------------------------------------------------
package stbl_pkg;

	localparam int GFX_BYTES_DEF = 65536;
	localparam int MAX_TILE_DEF  = 1023;
	localparam int SHEET_TILES   = 16;
	localparam int TILE_DIM      = 8;

	localparam int CFG_W   = 10;
	localparam int CFG_IW  = 2;
	localparam int ORG_W   = 9;
	localparam int FRM_W   = 10;
	localparam int POS_W   = 11;
	localparam int ID_W    = 11;
	localparam int WORD_W  = 14;
	localparam int ROW_CW  = 5;

	localparam logic [FRM_W-1:0] FRAME_W_RST = 10'd128;
	localparam logic [FRM_W-1:0] FRAME_H_RST = 10'd128;
	localparam logic [ROW_CW-1:0] LAST_SMALL = 5'd7;
	localparam logic [ROW_CW-1:0] LAST_BIG   = 5'd31;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ANCHOR_X     = 2'd0,
		CFG_ANCHOR_Y     = 2'd1,
		CFG_FRAME_WIDTH  = 2'd2,
		CFG_FRAME_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAW
	} seq_state_t;

	typedef struct packed {
		logic        en;
		logic [15:0] addr;
		logic [7:0]  data;
	} gfx_wr_t;

	typedef struct packed {
		logic [POS_W-1:0]  row_x;
		logic [POS_W-1:0]  row_y;
		logic [WORD_W-1:0] word;
		logic              tile_ok;
		logic              mirror_h;
		logic [2:0]        pal;
		logic              last;
	} row_ctl_t;

endpackage
`default_nettype wire

@@ design/stbl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbl_if
// Valid/ready channels: command beats in, row beats out.
// ----------------------------------------------------------------------------
interface stbl_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] gfx_addr;
	logic [7:0]  gfx_data;
	logic [7:0]  tile_x;
	logic [7:0]  tile_y;
	logic [9:0]  tile_id;
	logic        big_tile;
	logic        mirror_h;
	logic        mirror_v;
	logic [2:0]  palette_sel;

	modport source (
		output valid, cmd, gfx_addr, gfx_data, tile_x, tile_y, tile_id,
		       big_tile, mirror_h, mirror_v, palette_sel,
		input  ready
	);
	modport sink (
		input  valid, cmd, gfx_addr, gfx_data, tile_x, tile_y, tile_id,
		       big_tile, mirror_h, mirror_v, palette_sel,
		output ready
	);
endinterface

interface stbl_out_if;
	logic              valid;
	logic              ready;
	logic signed [10:0] row_x;
	logic signed [10:0] row_y;
	logic [7:0]        write_mask;
	logic [7:0]        pix0;
	logic [7:0]        pix1;
	logic [7:0]        pix2;
	logic [7:0]        pix3;
	logic [7:0]        pix4;
	logic [7:0]        pix5;
	logic [7:0]        pix6;
	logic [7:0]        pix7;
	logic              last_row;

	modport source (
		output valid, row_x, row_y, write_mask, pix0, pix1, pix2, pix3,
		       pix4, pix5, pix6, pix7, last_row,
		input  ready
	);
	modport sink (
		input  valid, row_x, row_y, write_mask, pix0, pix1, pix2, pix3,
		       pix4, pix5, pix6, pix7, last_row,
		output ready
	);
endinterface
`default_nettype wire

@@ design/stbl_gfx_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbl_gfx_mem
// Graphics store: 64-bit words, byte-lane writes, registered 8-byte reads.
// ----------------------------------------------------------------------------
module stbl_gfx_mem
	import stbl_pkg::*;
#(
	parameter int WORDS = GFX_BYTES_DEF / TILE_DIM,
	parameter int AW    = $clog2(WORDS)
) (
	input  wire logic          clk,
	input  wire gfx_wr_t       wr,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [63:0]        rd_data
);

	logic [63:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW+2:3]][wr.addr[2:0]*8 +: 8] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/stbl_row_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbl_row_seq
// Command decode and row sequencer: issues one store read per tile row.
// ----------------------------------------------------------------------------
module stbl_row_seq
	import stbl_pkg::*;
#(
	parameter int GFX_BYTES = GFX_BYTES_DEF,
	parameter int MAX_TILE  = MAX_TILE_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	stbl_in_if.sink               in_ch,
	input  wire logic [ORG_W-1:0] anchor_x,
	input  wire logic [ORG_W-1:0] anchor_y,
	input  wire logic             slot_free,
	output gfx_wr_t               wr,
	output logic                  issue,
	output row_ctl_t              ctl
);

	seq_state_t        state_q, state_nxt;
	logic [ROW_CW-1:0] cnt_q;
	logic [POS_W-1:0]  base_x_q, base_y_q;
	logic [9:0]        id_q;
	logic              big_q, mh_q, mv_q;
	logic [2:0]        pal_q;

	logic              in_acc, draw_acc, last;
	logic              hsel, vsel;
	logic [ID_W-1:0]   id_part;
	logic [2:0]        sy;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign draw_acc = in_acc && (in_ch.cmd == CMD_DRAW);

	assign hsel    = big_q & (cnt_q[3] ^ mh_q);
	assign vsel    = big_q & (cnt_q[4] ^ mv_q);
	assign id_part = {1'b0, id_q} + {10'd0, hsel} + {6'd0, vsel, 4'd0};
	assign sy      = cnt_q[2:0] ^ {3{mv_q}};
	assign last    = (cnt_q == (big_q ? LAST_BIG : LAST_SMALL));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (draw_acc) state_nxt = ST_DRAW;
			end
			ST_DRAW: begin
				if (slot_free && last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		issue       = 1'b0;
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_DRAW: issue = slot_free;
			default: ;
		endcase
	end

	always_comb begin
		wr.en   = in_acc && (in_ch.cmd == CMD_LOAD) &&
		          ({1'b0, in_ch.gfx_addr} < 17'(GFX_BYTES));
		wr.addr = in_ch.gfx_addr;
		wr.data = in_ch.gfx_data;

		ctl.row_x    = base_x_q + {7'd0, cnt_q[3] & big_q, 3'd0};
		ctl.row_y    = base_y_q + {7'd0, cnt_q[4] & big_q, cnt_q[2:0]};
		ctl.word     = {id_part[10:4], sy, id_part[3:0]};
		ctl.tile_ok  = ({21'd0, id_part} <= 32'(MAX_TILE));
		ctl.mirror_h = mh_q;
		ctl.pal      = pal_q;
		ctl.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (draw_acc) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			base_x_q <= {2'b00, anchor_x} + {{3{in_ch.tile_x[7]}}, in_ch.tile_x};
			base_y_q <= {2'b00, anchor_y} + {{3{in_ch.tile_y[7]}}, in_ch.tile_y};
			id_q     <= in_ch.tile_id;
			big_q    <= in_ch.big_tile;
			mh_q     <= in_ch.mirror_h;
			mv_q     <= in_ch.mirror_v;
			pal_q    <= in_ch.palette_sel;
		end
	end

endmodule
`default_nettype wire

@@ design/stbl_row_fmt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbl_row_fmt
// Turns a fetched 8-byte word into a row beat: mirror, palette, clip mask.
// ----------------------------------------------------------------------------
module stbl_row_fmt
	import stbl_pkg::*;
#(
	parameter int GFX_BYTES = GFX_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             issue,
	input  wire row_ctl_t         ctl,
	input  wire logic [63:0]      rd_data,
	input  wire logic [FRM_W-1:0] frame_width,
	input  wire logic [FRM_W-1:0] frame_height,
	output logic                  slot_free,
	stbl_out_if.source            out_ch
);

	logic     valid_s1;
	row_ctl_t ctl_s1;
	logic     adv;
	logic     out_valid_q;

	logic [7:0]  pix   [TILE_DIM];
	logic [7:0]  mask;
	logic        y_in;
	logic [11:0] dy;

	logic signed [10:0] row_x_q, row_y_q;
	logic [7:0]         mask_q;
	logic               last_q;
	logic [7:0]         pix_q [TILE_DIM];

	assign adv       = valid_s1 && (!out_valid_q || out_ch.ready);
	assign slot_free = !valid_s1 || adv;

	always_comb begin
		logic [2:0]  sx;
		logic [7:0]  p;
		logic [11:0] dx;
		logic        src_ok;
		dy   = {ctl_s1.row_y[10], ctl_s1.row_y};
		y_in = !dy[11] && (dy < {2'b00, frame_height});
		mask = '0;
		for (int i = 0; i < TILE_DIM; i++) begin
			sx     = 3'(i) ^ {3{ctl_s1.mirror_h}};
			src_ok = ctl_s1.tile_ok && ({ctl_s1.word, sx} < 17'(GFX_BYTES));
			p      = src_ok ? rd_data[sx*8 +: 8] : 8'd0;
			dx     = {ctl_s1.row_x[10], ctl_s1.row_x} + 12'(i);
			pix[i] = (p != 8'd0) ? (p + {1'b0, ctl_s1.pal, 4'd0}) : 8'd0;
			mask[i] = (p != 8'd0) && y_in && !dx[11] && (dx < {2'b00, frame_width});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctl_s1 <= ctl;
		end
		if (adv) begin
			row_x_q <= signed'(ctl_s1.row_x);
			row_y_q <= signed'(ctl_s1.row_y);
			mask_q  <= mask;
			last_q  <= ctl_s1.last;
			for (int i = 0; i < TILE_DIM; i++) begin
				pix_q[i] <= pix[i];
			end
		end
	end

	always_comb begin
		out_ch.valid      = out_valid_q;
		out_ch.row_x      = row_x_q;
		out_ch.row_y      = row_y_q;
		out_ch.write_mask = mask_q;
		out_ch.pix0       = pix_q[0];
		out_ch.pix1       = pix_q[1];
		out_ch.pix2       = pix_q[2];
		out_ch.pix3       = pix_q[3];
		out_ch.pix4       = pix_q[4];
		out_ch.pix5       = pix_q[5];
		out_ch.pix6       = pix_q[6];
		out_ch.pix7       = pix_q[7];
		out_ch.last_row   = last_q;
	end

endmodule
`default_nettype wire

@@ design/sprite_tile_row_blitter_core.sv @@
// Output: a draw beat's rows pass through the sequencer state, the store read
// register and the output register, then leave one row per cycle while the output
// is taken; 8 rows (8x8) or 32 rows (16x16). Each row takes one read of the graphics
// store read port (one 8-byte word); a draw holds off the input, a load does not.
// Reset: control state and configuration registers return to their defaults;
// graphics store contents stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_tile_row_blitter_core
// Sprite tile renderer over an 8-bit-per-pixel graphics store.
// ----------------------------------------------------------------------------
module sprite_tile_row_blitter_core
	import stbl_pkg::*;
#(
	parameter int GFX_BYTES = GFX_BYTES_DEF,
	parameter int MAX_TILE  = MAX_TILE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	stbl_in_if.sink                in_ch,
	stbl_out_if.source             out_ch,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_IW-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	localparam int WORDS = (GFX_BYTES + TILE_DIM - 1) / TILE_DIM;
	localparam int AW    = $clog2(WORDS);

	logic [ORG_W-1:0] anchor_x_q, anchor_y_q;
	logic [FRM_W-1:0] frame_w_q, frame_h_q;

	gfx_wr_t     wr;
	logic        issue, slot_free;
	row_ctl_t    ctl;
	logic [63:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			frame_w_q  <= FRAME_W_RST;
			frame_h_q  <= FRAME_H_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_ANCHOR_X:     anchor_x_q <= cfg_data[ORG_W-1:0];
				CFG_ANCHOR_Y:     anchor_y_q <= cfg_data[ORG_W-1:0];
				CFG_FRAME_WIDTH:  frame_w_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	stbl_row_seq #(
		.GFX_BYTES (GFX_BYTES),
		.MAX_TILE  (MAX_TILE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.anchor_x  (anchor_x_q),
		.anchor_y  (anchor_y_q),
		.slot_free (slot_free),
		.wr        (wr),
		.issue     (issue),
		.ctl       (ctl)
	);

	stbl_gfx_mem #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (issue),
		.rd_addr (ctl.word[AW-1:0]),
		.rd_data (rd_data)
	);

	stbl_row_fmt #(
		.GFX_BYTES (GFX_BYTES)
	) u_fmt (
		.clk          (clk),
		.arst_n       (arst_n),
		.issue        (issue),
		.ctl          (ctl),
		.rd_data      (rd_data),
		.frame_width  (frame_w_q),
		.frame_height (frame_h_q),
		.slot_free    (slot_free),
		.out_ch       (out_ch)
	);

endmodule
`default_nettype wire

@@ design/stbl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbl_checker
// Port-level checks for the sprite tile row blitter, bound to the top level.
// ----------------------------------------------------------------------------
module stbl_checker
	import stbl_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_mask,
	input wire logic        out_last
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_draw_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_cmd == CMD_DRAW) |=> !in_ready)
		else $error("input not held after draw beat");

	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_cmd == CMD_LOAD) |=> in_ready)
		else $error("input stalled after load beat");

	a_out_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mask) &&
		$stable(out_last))
		else $error("stalled row beat changed");

endmodule

bind sprite_tile_row_blitter_core stbl_checker u_stbl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_cmd    (in_ch.cmd),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_mask  (out_ch.write_mask),
	.out_last  (out_ch.last_row)
);
`default_nettype wire

@@ bench/sprite_tile_row_blitter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_tile_row_blitter_core_tb
// Self-checking bench for the sprite tile row blitter. A driver streams load
// and draw beats in random bursts. Before each draw, every store byte that the
// tile reads is loaded first. A monitor renders each accepted draw into the
// rows it should produce and checks the output beats against them in order.
// Register settings change between phases, while the block is idle.
// ----------------------------------------------------------------------------
module sprite_tile_row_blitter_core_tb;
	import stbl_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 9;
	localparam int BEATS_PER_PHASE = 9;

	typedef struct packed {
		logic        cmd;
		logic [15:0] gfx_addr;
		logic [7:0]  gfx_data;
		logic [7:0]  tile_x;
		logic [7:0]  tile_y;
		logic [9:0]  tile_id;
		logic        big_tile;
		logic        mirror_h;
		logic        mirror_v;
		logic [2:0]  palette_sel;
	} cmd_beat_t;

	typedef struct packed {
		logic [10:0]     row_x;
		logic [10:0]     row_y;
		logic [7:0]      mask;
		logic [7:0][7:0] pix;
		logic            last;
	} row_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic            cfg_wr_en;
	logic [CFG_IW-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_data;

	stbl_in_if  in_ch ();
	stbl_out_if out_ch ();

	sprite_tile_row_blitter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cmd_beat_t cmds_pending[$];
	row_beat_t rows_due[$];

	logic [7:0] gfx_mirror [0:GFX_BYTES_DEF-1];
	bit         gen_written [0:GFX_BYTES_DEF-1];
	int org_x = 0;
	int org_y = 0;
	int frm_w = 128;
	int frm_h = 128;

	// tiles whose bytes get loaded; 15 and 1023 also serve as 16x16 bases
	int tile_pool [5] = '{15, 16, 31, 32, 1023};

	int errors = 0;
	int n_loads = 0;
	int n_draws = 0;
	int n_big = 0;
	int n_rows = 0;
	int n_settings = 1;
	int idle_cycles = 0;
	bit in_taken = 1'b0;
	int drv_burst = 4;
	int drv_gap = 0;
	logic [15:0] stall_pat = 16'hFFFF;
	int stall_pos = 0;

	// ------------------------------------------------------------------
	// Row renderer
	// ------------------------------------------------------------------
	function automatic void render_part(int id, int x, int y, logic mh, logic mv,
			int pal_off, bit closes);
		row_beat_t r;
		int sy, sx, dy, dx, p, idx;
		for (int py = 0; py < TILE_DIM; py++) begin
			sy = mv ? TILE_DIM - 1 - py : py;
			dy = y + py;
			r = '0;
			r.row_x = x[10:0];
			r.row_y = dy[10:0];
			for (int px = 0; px < TILE_DIM; px++) begin
				sx = mh ? TILE_DIM - 1 - px : px;
				dx = x + px;
				p = 0;
				if (id <= MAX_TILE_DEF) begin
					idx = (id / SHEET_TILES) * 1024 + sy * 128 + (id % SHEET_TILES) * 8 + sx;
					if (idx < GFX_BYTES_DEF)
						p = gfx_mirror[idx];
				end
				if (p != 0) begin
					r.pix[px] = 8'(p + pal_off);
					if (dx >= 0 && dx < frm_w && dy >= 0 && dy < frm_h)
						r.mask[px] = 1'b1;
				end
			end
			r.last = closes && (py == TILE_DIM - 1);
			rows_due.push_back(r);
		end
	endfunction

	function automatic void render_tile(logic [7:0] tx, logic [7:0] ty, logic [9:0] id,
			logic big, logic mh, logic mv, logic [2:0] pal);
		int x, y, tl, tr, bl, br, t, off;
		x = org_x + (tx >= 128 ? int'(tx) - 256 : int'(tx));
		y = org_y + (ty >= 128 ? int'(ty) - 256 : int'(ty));
		off = int'(pal) * 16;
		if (!big) begin
			render_part(int'(id), x, y, mh, mv, off, 1'b1);
		end else begin
			tl = int'(id);
			tr = tl + 1;
			bl = tl + 16;
			br = tl + 17;
			if (mh) begin
				t = tl; tl = tr; tr = t;
				t = bl; bl = br; br = t;
			end
			if (mv) begin
				t = tl; tl = bl; bl = t;
				t = tr; tr = br; br = t;
			end
			render_part(tl, x, y, mh, mv, off, 1'b0);
			render_part(tr, x + TILE_DIM, y, mh, mv, off, 1'b0);
			render_part(bl, x, y + TILE_DIM, mh, mv, off, 1'b0);
			render_part(br, x + TILE_DIM, y + TILE_DIM, mh, mv, off, 1'b1);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	task automatic queue_load(int addr, logic [7:0] data);
		cmd_beat_t   b;
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		b = rnd[$bits(cmd_beat_t)-1:0];
		b.cmd = CMD_LOAD;
		b.gfx_addr = addr[15:0];
		b.gfx_data = data;
		gen_written[addr[15:0]] = 1'b1;
		cmds_pending.push_back(b);
	endtask

	// load every byte of a tile that has not been written yet
	task automatic prime_tile(int id);
		int a;
		if (id > MAX_TILE_DEF)
			return;
		for (int r = 0; r < TILE_DIM; r++) begin
			for (int c = 0; c < TILE_DIM; c++) begin
				a = (id / SHEET_TILES) * 1024 + r * 128 + (id % SHEET_TILES) * 8 + c;
				if (a < GFX_BYTES_DEF && !gen_written[a])
					queue_load(a, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
			end
		end
	endtask

	task automatic queue_draw(logic [7:0] tx, logic [7:0] ty, logic [9:0] id,
			logic big, logic mh, logic mv, logic [2:0] pal);
		cmd_beat_t   b;
		logic [63:0] rnd;
		prime_tile(int'(id));
		if (big) begin
			prime_tile(int'(id) + 1);
			prime_tile(int'(id) + 16);
			prime_tile(int'(id) + 17);
		end
		rnd = {$urandom, $urandom};
		b = rnd[$bits(cmd_beat_t)-1:0];
		b.cmd = CMD_DRAW;
		b.tile_x = tx;
		b.tile_y = ty;
		b.tile_id = id;
		b.big_tile = big;
		b.mirror_h = mh;
		b.mirror_v = mv;
		b.palette_sel = pal;
		cmds_pending.push_back(b);
	endtask

	task automatic add_random_beat();
		logic [9:0] id;
		logic       big;
		if ($urandom_range(0, 99) < 15) begin
			queue_load(int'(16'($urandom)), 8'($urandom));
		end else begin
			big = ($urandom_range(0, 9) < 4);
			if (big)
				id = ($urandom_range(0, 1) == 0) ? 10'd15 : 10'd1023;
			else
				id = 10'(tile_pool[$urandom_range(0, 4)]);
			queue_draw(8'($urandom), 8'($urandom), id, big,
				1'($urandom), 1'($urandom), 3'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (!(cmds_pending.size() == 0 && !in_ch.valid && rows_due.size() == 0))
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_ANCHOR_X:     org_x = value;
			CFG_ANCHOR_Y:     org_y = value;
			CFG_FRAME_WIDTH:  frm_w = value;
			CFG_FRAME_HEIGHT: frm_h = value;
			default: ;
		endcase
	endtask

	task automatic apply_regs(int ox, int oy, int fw, int fh);
		wait_drained();
		repeat (8) @(posedge clk);
		write_reg(CFG_ANCHOR_X, ox);
		write_reg(CFG_ANCHOR_Y, oy);
		write_reg(CFG_FRAME_WIDTH, fw);
		write_reg(CFG_FRAME_HEIGHT, fh);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts with random gaps
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			if (drv_gap > 0) begin
				drv_gap--;
				in_ch.valid <= 1'b0;
			end else if (cmds_pending.size() > 0) begin
				cmd_beat_t b;
				b = cmds_pending.pop_front();
				in_ch.cmd <= b.cmd;
				in_ch.gfx_addr <= b.gfx_addr;
				in_ch.gfx_data <= b.gfx_data;
				in_ch.tile_x <= b.tile_x;
				in_ch.tile_y <= b.tile_y;
				in_ch.tile_id <= b.tile_id;
				in_ch.big_tile <= b.big_tile;
				in_ch.mirror_h <= b.mirror_h;
				in_ch.mirror_v <= b.mirror_v;
				in_ch.palette_sel <= b.palette_sel;
				in_ch.valid <= 1'b1;
				drv_burst--;
				if (drv_burst <= 0) begin
					drv_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					drv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, reloaded once all its bits are used
	always @(negedge clk) begin
		out_ch.ready <= stall_pat[stall_pos];
		stall_pos++;
		if (stall_pos == 16) begin
			stall_pos = 0;
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;
				1: stall_pat = 16'($urandom) | 16'h0101;
				2: stall_pat = 16'h0001;
				default: stall_pat = 16'($urandom);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string field, logic [10:0] want, logic [10:0] got);
		errors++;
		$display("%0t: row %0d %s mismatch, expected %h got %h", $time, n_rows, field,
			want, got);
	endtask

	always @(posedge clk) begin
		row_beat_t want, got;
		in_taken = in_ch.valid && in_ch.ready;
		if (in_taken) begin
			if (in_ch.cmd == CMD_LOAD) begin
				gfx_mirror[in_ch.gfx_addr] = in_ch.gfx_data;
				n_loads++;
			end else begin
				render_tile(in_ch.tile_x, in_ch.tile_y, in_ch.tile_id, in_ch.big_tile,
					in_ch.mirror_h, in_ch.mirror_v, in_ch.palette_sel);
				n_draws++;
				if (in_ch.big_tile)
					n_big++;
			end
		end
		if (out_ch.valid && out_ch.ready) begin
			got.row_x = out_ch.row_x;
			got.row_y = out_ch.row_y;
			got.mask = out_ch.write_mask;
			got.pix = {out_ch.pix7, out_ch.pix6, out_ch.pix5, out_ch.pix4,
				out_ch.pix3, out_ch.pix2, out_ch.pix1, out_ch.pix0};
			got.last = out_ch.last_row;
			if (rows_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected row beat, expected none got x=%h y=%h", $time,
					got.row_x, got.row_y);
			end else begin
				want = rows_due.pop_front();
				if (got.row_x !== want.row_x)
					flag_mismatch("row_x", want.row_x, got.row_x);
				if (got.row_y !== want.row_y)
					flag_mismatch("row_y", want.row_y, got.row_y);
				if (got.mask !== want.mask)
					flag_mismatch("write_mask", 11'(want.mask), 11'(got.mask));
				for (int i = 0; i < TILE_DIM; i++)
					if (got.pix[i] !== want.pix[i])
						flag_mismatch($sformatf("pix%0d", i), 11'(want.pix[i]),
							11'(got.pix[i]));
				if (got.last !== want.last)
					flag_mismatch("last_row", 11'(want.last), 11'(got.last));
			end
			n_rows++;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d rows outstanding", $time,
					idle_cycles, rows_due.size());
				$display("FAIL sprite_tile_row_blitter_core");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_LOAD;
		in_ch.gfx_addr = '0;
		in_ch.gfx_data = '0;
		in_ch.tile_x = '0;
		in_ch.tile_y = '0;
		in_ch.tile_id = '0;
		in_ch.big_tile = 1'b0;
		in_ch.mirror_h = 1'b0;
		in_ch.mirror_v = 1'b0;
		in_ch.palette_sel = '0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				1: apply_regs(0, 0, 512, 512);
				2: apply_regs(511, 511, 512, 512);
				3: apply_regs(0, 0, 1, 1);
				4: apply_regs(64, 32, 0, 0);
				default: apply_regs($urandom_range(0, 200), $urandom_range(0, 200),
					$urandom_range(0, 1) ? $urandom_range(1, 512) : $urandom_range(1, 160),
					$urandom_range(0, 1) ? $urandom_range(1, 512) : $urandom_range(1, 160));
			endcase
			if (ph == 0) begin
				// mirroring on both sizes, 16x16 spans a sheet row boundary
				queue_draw(8'h00, 8'h00, 10'd15, 1'b0, 1'b0, 1'b0, 3'd0);
				queue_draw(8'h00, 8'h00, 10'd15, 1'b0, 1'b1, 1'b0, 3'd1);
				queue_draw(8'h00, 8'h00, 10'd15, 1'b0, 1'b0, 1'b1, 3'd2);
				queue_draw(8'h00, 8'h00, 10'd15, 1'b0, 1'b1, 1'b1, 3'd7);
				queue_draw(8'h10, 8'h10, 10'd15, 1'b1, 1'b0, 1'b0, 3'd3);
				queue_draw(8'h10, 8'h10, 10'd15, 1'b1, 1'b1, 1'b0, 3'd4);
				queue_draw(8'h10, 8'h10, 10'd15, 1'b1, 1'b0, 1'b1, 3'd5);
				queue_draw(8'h10, 8'h10, 10'd15, 1'b1, 1'b1, 1'b1, 3'd6);
				// offset extremes and frame edges
				queue_draw(8'h7F, 8'h7F, 10'd16, 1'b0, 1'b0, 1'b0, 3'd0);
				queue_draw(8'h80, 8'h80, 10'd31, 1'b0, 1'b0, 1'b0, 3'd1);
				queue_draw(8'hFF, 8'hF9, 10'd15, 1'b1, 1'b0, 1'b0, 3'd2);
				queue_draw(8'h7A, 8'h00, 10'd15, 1'b1, 1'b1, 1'b0, 3'd7);
				// last tile, parts past the tile range
				queue_draw(8'h08, 8'h08, 10'd1023, 1'b0, 1'b0, 1'b0, 3'd0);
				queue_draw(8'h08, 8'h08, 10'd1023, 1'b1, 1'b1, 1'b0, 3'd1);
				// overwrite a byte, palette add wraps past 255
				queue_load(120, 8'hFF);
				queue_draw(8'h00, 8'h00, 10'd15, 1'b0, 1'b0, 1'b0, 3'd7);
			end
			repeat (BEATS_PER_PHASE) add_random_beat();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d loads and %0d draws (%0d of them 16x16) under %0d settings;",
			n_loads, n_draws, n_big, n_settings);
		$display("%0d row beats checked, %0d mismatches.", n_rows, errors);
		if (errors == 0)
			$display("PASS sprite_tile_row_blitter_core");
		else
			$display("FAIL sprite_tile_row_blitter_core");
		$finish;
	end

endmodule

@@ files.f @@
design/stbl_pkg.sv
design/stbl_if.sv
design/stbl_gfx_mem.sv
design/stbl_row_seq.sv
design/stbl_row_fmt.sv
design/sprite_tile_row_blitter_core.sv
design/stbl_checker.sv
bench/sprite_tile_row_blitter_core_tb.sv
